FILE: src/qts_pkg.sv
package qts_pkg;

   // Default widths and set depth
   localparam int unsigned POSITION_BITS_DEF = 16;
   localparam int unsigned SET_SLOTS_DEF     = 8;

   // Register reset values
   localparam logic [63:0] BLANK_SET_RST = 64'd2336;
   localparam logic [63:0] CITE_SET_RST  = 64'd10018;
   localparam logic [63:0] SEP_SET_RST   = 64'd189147187488;
   localparam logic [15:0] WBS_RST       = 16'd256;

   // Result status codes
   typedef enum logic [2:0] {
      ST_TOKEN        = 3'd0,
      ST_LONG         = 3'd1,
      ST_QUOTE_IN_WORD = 3'd2,
      ST_UNTERMINATED = 3'd3,
      ST_LINE_END     = 3'd4
   } status_type;

   // Scanner mode
   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_WORD  = 2'd1,
      MODE_QUOTE = 2'd2
   } mode_type;

   // Register map
   typedef enum logic [1:0] {
      CSR_BLANK_SET = 2'd0,
      CSR_CITE_SET  = 2'd1,
      CSR_SEP_SET   = 2'd2,
      CSR_WBS       = 2'd3
   } csr_index_type;

   // One result word
   typedef struct packed {
      status_type  status;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } result_type;

   // Byte-slot set match; a zero slot never matches
   function automatic logic in_set(input logic [63:0] set, input logic [7:0] c,
                                   input int unsigned slots);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 8; k++) begin
         if (k < slots && set[8*k +: 8] != 8'd0 && set[8*k +: 8] == c) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

FILE: src/quoted_token_scanner_top.sv
// Channel   Direction  Handshake           Word
// req_      in         req_valid/stall     req_char_code
// rsp_      out        rsp_valid/stall     status, token_start, token_length, last
// csr_      in         csr_valid/ready     csr_index, csr_data
//
// One character is taken per cycle while req_stall is low; it is registered,
// then classified and scanned once the queue has room for two words, pushing
// zero, one or two result words into a four-word output queue. Sustained rate
// is one character per cycle as long as results are drained one per cycle;
// two-result characters drain one word at a time. req_stall rises while the
// queue holds more than two words and a character waits. Reset is synchronous
// and restores the register defaults and an empty, idle scanner.
module quoted_token_scanner_top #(
   parameter int unsigned POSITION_BITS = qts_pkg::POSITION_BITS_DEF,
   parameter int unsigned SET_SLOTS     = qts_pkg::SET_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int unsigned PB = POSITION_BITS;

   // Configuration registers
   logic [63:0] blank_ff, cite_ff, sep_ff;
   logic [15:0] wbs_ff;

   // Input register
   logic       c_vld_ff;
   logic [7:0] c_ff;

   // Scanner state
   qts_pkg::mode_type mode_ff, mode_in;
   logic [PB-1:0]     start_ff, start_in;
   logic [PB-1:0]     pos_ff, pos_in;

   // Output queue
   qts_pkg::result_type q_ff [4];
   logic [1:0] head_ff, tail_ff;
   logic [2:0] count_ff;

   logic proc, pop;
   qts_pkg::result_type res0, res1;
   logic [1:0] n_res;

   logic [PB-1:0] pos_inc, len;
   logic is_blank, is_cite, is_sep, len_long, one_long;

   // Build one result word, fields cut or extended to 16 bits
   function automatic qts_pkg::result_type mk(input qts_pkg::status_type st,
                                              input logic [PB-1:0] s,
                                              input logic [PB-1:0] l);
      qts_pkg::result_type r;
      logic [47:0] sw, lw;
      sw = 48'(s);
      lw = 48'(l);
      r.status = st;
      r.start  = sw[15:0];
      r.length = lw[15:0];
      r.last   = 1'b0;
      return r;
   endfunction

   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ff <= qts_pkg::BLANK_SET_RST;
         cite_ff  <= qts_pkg::CITE_SET_RST;
         sep_ff   <= qts_pkg::SEP_SET_RST;
         wbs_ff   <= qts_pkg::WBS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (qts_pkg::csr_index_type'(csr_index))
            qts_pkg::CSR_BLANK_SET: blank_ff <= csr_data;
            qts_pkg::CSR_CITE_SET:  cite_ff  <= csr_data;
            qts_pkg::CSR_SEP_SET:   sep_ff   <= csr_data;
            qts_pkg::CSR_WBS:       wbs_ff   <= csr_data[15:0];
         endcase
      end
   end

   // Handshakes: scan when the queue has room for two words
   assign proc      = c_vld_ff && (count_ff <= 3'd2);
   assign req_stall = c_vld_ff && !proc;
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         c_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         c_ff <= req_char_code;
      end
   end

   // Character classes and length checks
   assign is_blank = qts_pkg::in_set(blank_ff, c_ff, SET_SLOTS);
   assign is_cite  = qts_pkg::in_set(cite_ff, c_ff, SET_SLOTS);
   assign is_sep   = qts_pkg::in_set(sep_ff, c_ff, SET_SLOTS);
   assign pos_inc  = (pos_ff == '1) ? pos_ff : pos_ff + PB'(1);
   assign len      = pos_ff - start_ff;
   assign len_long = (33'(len) + 33'd1) > 33'(wbs_ff);
   assign one_long = wbs_ff < 16'd2;

   // Scan step
   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      n_res    = 2'd0;
      res0     = mk(qts_pkg::ST_TOKEN, start_ff, len);
      res1     = mk(qts_pkg::ST_LINE_END, pos_ff, '0);
      if (c_ff == 8'd0) begin
         // end of line: flush pending token, then line end
         case (mode_ff)
            qts_pkg::MODE_WORD: begin
               res0  = mk(len_long ? qts_pkg::ST_LONG : qts_pkg::ST_TOKEN, start_ff, len);
               n_res = 2'd2;
            end
            qts_pkg::MODE_QUOTE: begin
               res0  = mk(qts_pkg::ST_UNTERMINATED, start_ff, len);
               n_res = 2'd2;
            end
            default: begin
               res0  = mk(qts_pkg::ST_LINE_END, pos_ff, '0);
               n_res = 2'd1;
            end
         endcase
         mode_in  = qts_pkg::MODE_IDLE;
         start_in = '0;
         pos_in   = '0;
      end else begin
         case (mode_ff)
            qts_pkg::MODE_WORD: begin
               priority if (is_cite) begin
                  res0     = mk(qts_pkg::ST_QUOTE_IN_WORD, start_ff, len);
                  n_res    = 2'd1;
                  mode_in  = qts_pkg::MODE_QUOTE;
                  start_in = pos_inc;
                  pos_in   = pos_inc;
               end else if (is_sep) begin
                  // word ends; a non-blank separator is its own token
                  res0    = mk(len_long ? qts_pkg::ST_LONG : qts_pkg::ST_TOKEN, start_ff, len);
                  res1    = mk(one_long ? qts_pkg::ST_LONG : qts_pkg::ST_TOKEN, pos_ff,
                               PB'(1));
                  n_res   = is_blank ? 2'd1 : 2'd2;
                  mode_in = qts_pkg::MODE_IDLE;
                  pos_in  = pos_inc;
               end else begin
                  pos_in = pos_inc;
               end
            end
            qts_pkg::MODE_QUOTE: begin
               if (is_cite) begin
                  res0    = mk(len_long ? qts_pkg::ST_LONG : qts_pkg::ST_TOKEN, start_ff, len);
                  n_res   = 2'd1;
                  mode_in = qts_pkg::MODE_IDLE;
               end
               pos_in = pos_inc;
            end
            default: begin
               mode_in = qts_pkg::MODE_IDLE;
               priority if (is_blank) begin
                  pos_in = pos_inc;
               end else if (is_cite) begin
                  mode_in  = qts_pkg::MODE_QUOTE;
                  start_in = pos_inc;
                  pos_in   = pos_inc;
               end else if (is_sep) begin
                  res0   = mk(one_long ? qts_pkg::ST_LONG : qts_pkg::ST_TOKEN, pos_ff, PB'(1));
                  n_res  = 2'd1;
                  pos_in = pos_inc;
               end else begin
                  mode_in  = qts_pkg::MODE_WORD;
                  start_in = pos_ff;
                  pos_in   = pos_inc;
               end
            end
         endcase
      end
      // flag the final word of this character
      if (n_res == 2'd1) begin
         res0.last = 1'b1;
      end
      res1.last = 1'b1;
   end

   // Scanner state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= qts_pkg::MODE_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
      end else if (proc) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
      end
   end

   // Output queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (pop) begin
            head_ff <= head_ff + 2'd1;
         end
         if (proc) begin
            tail_ff <= tail_ff + n_res;
         end
         count_ff <= count_ff + (proc ? 3'(n_res) : 3'd0) - (pop ? 3'd1 : 3'd0);
      end
   end

   // Output queue storage
   always_ff @(posedge clock) begin
      if (proc && n_res != 2'd0) begin
         q_ff[tail_ff] <= res0;
      end
      if (proc && n_res == 2'd2) begin
         q_ff[tail_ff + 2'd1] <= res1;
      end
   end

   assign rsp_valid        = count_ff != 3'd0;
   assign rsp_status       = q_ff[head_ff].status;
   assign rsp_token_start  = q_ff[head_ff].start;
   assign rsp_token_length = q_ff[head_ff].length;
   assign rsp_last         = q_ff[head_ff].last;

endmodule

FILE: src/qts_checker.sv
module qts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_token_length,
   input logic        rsp_last
);

   // Queue is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // A stalled word stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Line end is zero length and closes the character
   a_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == qts_pkg::ST_LINE_END |-> rsp_token_length == 16'd0 && rsp_last)
      else $error("malformed line end word");

   // An unterminated quote is never flagged last; a line end always follows it
   a_unterm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == qts_pkg::ST_UNTERMINATED |-> !rsp_last)
      else $error("unterminated quote flagged last");

   // A quote inside a word is the only word of its character
   a_qiw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == qts_pkg::ST_QUOTE_IN_WORD |-> rsp_last)
      else $error("quote inside word not flagged last");

endmodule

bind quoted_token_scanner_top qts_checker u_qts_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_token_length (rsp_token_length),
   .rsp_last         (rsp_last)
);
